[src/rle_pkg.sv]
// rle_pkg: shared types and constants of the run-length packet encoder.
// No dependencies; rle_ctrl, rle_lane_pack and the top refer to it by scoped names.
package rle_pkg;

	localparam int unsigned LIT_AW    = 7;
	localparam int unsigned LIT_DEPTH = 128;
	localparam int unsigned LANE_W    = 64;
	localparam int unsigned BCNT_W    = 4;

	localparam logic [7:0] RUN_FLAG = 8'h80;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FL_HDR,
		ST_FL_DATA,
		ST_RUN_HDR,
		ST_RUN_VAL,
		ST_DRAIN
	} ctrl_state_t;

	typedef struct packed {
		logic       vld;
		logic [7:0] dat;
		logic       last;
	} byte_tok_t;

endpackage

[src/rle_in_if.sv]
// rle_in_if: input channel of the encoder, one raw byte per word.
// Depends on nothing.
interface rle_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       block_end;

	modport source (output valid, output data_byte, output block_end, input ready);
	modport sink (input valid, input data_byte, input block_end, output ready);
endinterface

[src/rle_out_if.sv]
// rle_out_if: output channel of the encoder, up to eight encoded bytes per word.
// Depends on nothing.
interface rle_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] packed_bytes;
	logic [3:0]  byte_count;
	logic        block_done;

	modport source (output valid, output packed_bytes, output byte_count,
		output block_done, input ready);
	modport sink (input valid, input packed_bytes, input byte_count,
		input block_done, output ready);
endinterface

[src/rle_ctrl.sv]
// rle_ctrl: window, run tracking and the literal store memory; sequences
// packets into a byte stream. Depends on rle_pkg and rle_in_if.
module rle_ctrl #(
	parameter int unsigned MAX_PACKET = 126,
	parameter int unsigned MIN_REPEAT = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	rle_in_if.sink            din,
	output rle_pkg::byte_tok_t tok,
	input  logic              tok_rdy
);

	localparam int unsigned WD = MIN_REPEAT - 1;
	localparam int unsigned FW = $clog2(WD + 1);
	localparam int unsigned AW = rle_pkg::LIT_AW;

	rle_pkg::ctrl_state_t state_q, state_nx;

	logic [7:0]    win_q [WD];
	logic [FW-1:0] fill_q;
	logic [AW-1:0] cnt_q;
	logic [AW-1:0] idx_q;
	logic          run_act_q;
	logic [6:0]    run_len_q;
	logic [7:0]    run_val_q;
	logic          last_q;
	logic          brk_q;

	logic [7:0]    mem [rle_pkg::LIT_DEPTH];
	logic [7:0]    rd_q;
	logic          mem_we;
	logic          mem_re;
	logic [AW-1:0] mem_ra;

	logic          acc;
	logic          all_eq;
	logic          extend;
	logic          win_full;
	logic [AW:0]   cnt_inc;
	logic          cnt_hit;
	logic          fl_end;
	logic          fl_mark;

	always_comb begin
		all_eq = (fill_q == FW'(WD));
		for (int k = 0; k < WD; k++) begin
			if (win_q[k] != din.data_byte)
				all_eq = 1'b0;
		end
	end

	assign acc      = din.valid && din.ready;
	assign win_full = (fill_q == FW'(WD));
	assign extend   = run_act_q && (din.data_byte == run_val_q)
		&& (run_len_q < 7'(MAX_PACKET));
	assign cnt_inc  = {1'b0, cnt_q} + 1'b1;
	assign cnt_hit  = (cnt_inc == (AW + 1)'(MAX_PACKET));
	assign fl_end   = (idx_q == cnt_q - 1'b1);
	assign fl_mark  = fl_end && last_q && !run_act_q && (fill_q == '0);

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			rle_pkg::ST_IDLE: begin
				if (acc) begin
					if (run_act_q) begin
						if (extend)
							state_nx = din.block_end ? rle_pkg::ST_RUN_HDR : rle_pkg::ST_IDLE;
						else
							state_nx = rle_pkg::ST_RUN_HDR;
					end else if (all_eq) begin
						if (cnt_q != '0)
							state_nx = rle_pkg::ST_FL_HDR;
						else
							state_nx = din.block_end ? rle_pkg::ST_RUN_HDR : rle_pkg::ST_IDLE;
					end else if (win_full && cnt_hit) begin
						state_nx = rle_pkg::ST_FL_HDR;
					end else begin
						state_nx = din.block_end ? rle_pkg::ST_DRAIN : rle_pkg::ST_IDLE;
					end
				end
			end
			rle_pkg::ST_FL_HDR: begin
				if (tok_rdy)
					state_nx = rle_pkg::ST_FL_DATA;
			end
			rle_pkg::ST_FL_DATA: begin
				if (tok_rdy && fl_end) begin
					if (!last_q)
						state_nx = rle_pkg::ST_IDLE;
					else if (run_act_q)
						state_nx = rle_pkg::ST_RUN_HDR;
					else if (fill_q != '0)
						state_nx = rle_pkg::ST_DRAIN;
					else
						state_nx = rle_pkg::ST_IDLE;
				end
			end
			rle_pkg::ST_RUN_HDR: begin
				if (tok_rdy)
					state_nx = rle_pkg::ST_RUN_VAL;
			end
			rle_pkg::ST_RUN_VAL: begin
				if (tok_rdy)
					state_nx = (brk_q && last_q) ? rle_pkg::ST_DRAIN : rle_pkg::ST_IDLE;
			end
			rle_pkg::ST_DRAIN: begin
				if ((fill_q == FW'(1)) || cnt_hit)
					state_nx = rle_pkg::ST_FL_HDR;
			end
			default: state_nx = rle_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		din.ready = 1'b0;
		tok       = '0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_ra    = '0;
		unique case (state_q)
			rle_pkg::ST_IDLE: begin
				din.ready = 1'b1;
				mem_we    = acc && !run_act_q && !all_eq && win_full;
			end
			rle_pkg::ST_FL_HDR: begin
				tok.vld = 1'b1;
				tok.dat = {1'b0, cnt_q};
				mem_re  = tok_rdy;
			end
			rle_pkg::ST_FL_DATA: begin
				tok.vld  = 1'b1;
				tok.dat  = rd_q;
				tok.last = fl_mark;
				mem_re   = tok_rdy && !fl_end;
				mem_ra   = idx_q + 1'b1;
			end
			rle_pkg::ST_RUN_HDR: begin
				tok.vld = 1'b1;
				tok.dat = rle_pkg::RUN_FLAG | {1'b0, run_len_q};
			end
			rle_pkg::ST_RUN_VAL: begin
				tok.vld  = 1'b1;
				tok.dat  = run_val_q;
				tok.last = !brk_q;
			end
			rle_pkg::ST_DRAIN: begin
				mem_we = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= rle_pkg::ST_IDLE;
			for (int k = 0; k < WD; k++)
				win_q[k] <= '0;
			fill_q    <= '0;
			cnt_q     <= '0;
			idx_q     <= '0;
			run_act_q <= 1'b0;
			run_len_q <= '0;
			run_val_q <= '0;
			last_q    <= 1'b0;
			brk_q     <= 1'b0;
		end else begin
			state_q <= state_nx;
			case (state_q)
				rle_pkg::ST_IDLE: begin
					if (acc) begin
						last_q <= din.block_end;
						brk_q  <= run_act_q && !extend;
						if (run_act_q) begin
							if (extend) begin
								run_len_q <= run_len_q + 1'b1;
							end else begin
								win_q[0] <= din.data_byte;
								fill_q   <= FW'(1);
							end
						end else if (all_eq) begin
							run_act_q <= 1'b1;
							run_len_q <= 7'(MIN_REPEAT);
							run_val_q <= din.data_byte;
							fill_q    <= '0;
						end else if (win_full) begin
							for (int k = 0; k < WD - 1; k++)
								win_q[k] <= win_q[k+1];
							win_q[WD-1] <= din.data_byte;
							cnt_q       <= cnt_inc[AW-1:0];
						end else begin
							for (int k = 0; k < WD; k++) begin
								if (fill_q == FW'(k))
									win_q[k] <= din.data_byte;
							end
							fill_q <= fill_q + 1'b1;
						end
					end
				end
				rle_pkg::ST_FL_HDR: begin
					if (tok_rdy)
						idx_q <= '0;
				end
				rle_pkg::ST_FL_DATA: begin
					if (tok_rdy) begin
						if (fl_end)
							cnt_q <= '0;
						else
							idx_q <= idx_q + 1'b1;
					end
				end
				rle_pkg::ST_RUN_VAL: begin
					if (tok_rdy) begin
						run_act_q <= 1'b0;
						run_len_q <= '0;
						run_val_q <= '0;
					end
				end
				rle_pkg::ST_DRAIN: begin
					for (int k = 0; k < WD - 1; k++)
						win_q[k] <= win_q[k+1];
					fill_q <= fill_q - 1'b1;
					cnt_q  <= cnt_inc[AW-1:0];
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[cnt_q] <= win_q[0];
		if (mem_re)
			rd_q <= mem[mem_ra];
	end

`ifndef SYNTHESIS
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("literal store written and read in one cycle");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, cnt_q} <= (AW + 1)'(MAX_PACKET))
		else $error("literal count passed packet limit without flush");
	a_run_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rle_pkg::ST_IDLE && run_act_q) |-> (fill_q == '0))
		else $error("window holds bytes during a run");
	a_run_len: assert property (@(posedge clk) disable iff (!arst_n)
		run_act_q |-> (run_len_q >= 7'(MIN_REPEAT) && run_len_q <= 7'(MAX_PACKET)))
		else $error("run length out of range");
`endif

endmodule

[src/rle_lane_pack.sv]
// rle_lane_pack: packs the encoded byte stream into output words of up to
// eight bytes, with an output register. Depends on rle_pkg and rle_out_if.
module rle_lane_pack #(
	parameter int unsigned OUT_LANES = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  rle_pkg::byte_tok_t tok,
	output logic               tok_rdy,
	rle_out_if.source          dout
);

	localparam int unsigned LW = rle_pkg::LANE_W;
	localparam int unsigned CW = rle_pkg::BCNT_W;

	logic [LW-1:0] lane_q;
	logic [CW-1:0] fill_q;
	logic          out_vld_q;
	logic [LW-1:0] out_dat_q;
	logic [CW-1:0] out_cnt_q;
	logic          out_done_q;

	logic [LW-1:0] lane_nx;
	logic [CW-1:0] fill_inc;
	logic          tok_acc;
	logic          emit;

	assign tok_rdy  = !out_vld_q || dout.ready;
	assign tok_acc  = tok.vld && tok_rdy;
	assign fill_inc = fill_q + 1'b1;
	assign emit     = tok_acc && ((fill_inc == CW'(OUT_LANES)) || tok.last);

	always_comb begin
		lane_nx = lane_q;
		for (int k = 0; k < OUT_LANES; k++) begin
			if (fill_q == CW'(k))
				lane_nx[8*k +: 8] = tok.dat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_q     <= '0;
			fill_q     <= '0;
			out_vld_q  <= 1'b0;
			out_dat_q  <= '0;
			out_cnt_q  <= '0;
			out_done_q <= 1'b0;
		end else begin
			if (emit) begin
				out_vld_q  <= 1'b1;
				out_dat_q  <= lane_nx;
				out_cnt_q  <= fill_inc;
				out_done_q <= tok.last;
				lane_q     <= '0;
				fill_q     <= '0;
			end else begin
				if (dout.ready)
					out_vld_q <= 1'b0;
				if (tok_acc) begin
					lane_q <= lane_nx;
					fill_q <= fill_inc;
				end
			end
		end
	end

	assign dout.valid        = out_vld_q;
	assign dout.packed_bytes = out_dat_q;
	assign dout.byte_count   = out_cnt_q;
	assign dout.block_done   = out_done_q;

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q < CW'(OUT_LANES))
		else $error("staging lane overfilled");
	a_word_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> (out_cnt_q != '0 && out_cnt_q <= CW'(OUT_LANES)))
		else $error("output word with bad byte count");
	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(tok_acc && tok.last) |=> (out_vld_q && out_done_q && fill_q == '0))
		else $error("last byte did not close the block");
`endif

endmodule

[src/rle_packet_encoder_top.sv]
// Run-length packet encoder: one raw byte per input word, encoded bytes packed up to
// OUT_LANES per output word, valid in the cycle after its final byte is accepted.
// A byte that closes no packet is taken in idle; a repeat packet adds header and value
// states, a literal packet a header and a store read per literal (one byte per cycle
// unless stalled), each drained window byte a drain step; stalls hold the packet states.
// arst_n clears control state and the staging lane; the literal store is not cleared.
module rle_packet_encoder_top #(
	parameter int unsigned MAX_PACKET = 126,
	parameter int unsigned MIN_REPEAT = 4,
	parameter int unsigned OUT_LANES  = 8
) (
	input logic       clk,
	input logic       arst_n,
	rle_in_if.sink    din,
	rle_out_if.source dout
);

	rle_pkg::byte_tok_t tok;
	logic               tok_rdy;

	rle_ctrl #(
		.MAX_PACKET (MAX_PACKET),
		.MIN_REPEAT (MIN_REPEAT)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.din     (din),
		.tok     (tok),
		.tok_rdy (tok_rdy)
	);

	rle_lane_pack #(
		.OUT_LANES (OUT_LANES)
	) u_pack (
		.clk     (clk),
		.arst_n  (arst_n),
		.tok     (tok),
		.tok_rdy (tok_rdy),
		.dout    (dout)
	);

endmodule
